FILE: rtl/core/cic_pkg.sv
// shared types and constants for the colored inversion counter
package cic_pkg;

	localparam int TOTAL_BITS = 19;
	localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = '1;

	// control bits that travel with a request down the cell chain
	typedef struct packed {
		logic valid;
		logic last;
		logic ovf;
	} cic_ctl_t;

endpackage

FILE: rtl/core/cic_in_if.sv
// input channel: one item per request
interface cic_in_if #(
	parameter int VALUE_BITS = 32,
	parameter int COLOR_BITS = 10
);
	logic                  valid;
	logic                  ready;
	logic [VALUE_BITS-1:0] item_value;
	logic [COLOR_BITS-1:0] item_color;
	logic                  is_last;

	modport source (output valid, output item_value, output item_color, output is_last,
		input ready);
	modport sink (input valid, input item_value, input item_color, input is_last,
		output ready);
endinterface

FILE: rtl/core/cic_out_if.sv
// output channel: one sequence result per request
interface cic_out_if;
	logic        valid;
	logic        ready;
	logic [18:0] pair_total;
	logic        overflowed;

	modport source (output valid, output pair_total, output overflowed, input ready);
	modport sink (input valid, input pair_total, input overflowed, output ready);
endinterface

FILE: rtl/core/cic_cell.sv
// one chain cell: holds one item, counts crossings for a passing request
module cic_cell #(
	parameter int CELL_IDX   = 0,
	parameter int MAX_ITEMS  = 1024,
	parameter int VALUE_BITS = 32,
	parameter int COLOR_BITS = 10
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          adv,
	input  cic_pkg::cic_ctl_t             ctl_in,
	input  logic [VALUE_BITS-1:0]         val_in,
	input  logic [COLOR_BITS-1:0]         col_in,
	input  logic [$clog2(MAX_ITEMS)-1:0]  idx_in,
	input  logic [$clog2(MAX_ITEMS)-1:0]  cnt_in,
	output cic_pkg::cic_ctl_t             ctl_out,
	output logic [VALUE_BITS-1:0]         val_out,
	output logic [COLOR_BITS-1:0]         col_out,
	output logic [$clog2(MAX_ITEMS)-1:0]  idx_out,
	output logic [$clog2(MAX_ITEMS)-1:0]  cnt_out
);
	import cic_pkg::*;

	localparam int IDX_BITS = $clog2(MAX_ITEMS);
	localparam logic [IDX_BITS-1:0] MY_IDX = IDX_BITS'(CELL_IDX);

	logic [VALUE_BITS-1:0] held_val_q;
	logic [COLOR_BITS-1:0] held_col_q;
	cic_ctl_t              ctl_q;
	logic [VALUE_BITS-1:0] val_q;
	logic [COLOR_BITS-1:0] col_q;
	logic [IDX_BITS-1:0]   idx_q;
	logic [IDX_BITS-1:0]   cnt_q;
	logic                  live;
	logic                  hit;
	logic                  wr;

	// only items that arrived earlier sit below the request's own slot
	assign live = ctl_in.valid && !ctl_in.ovf;
	assign hit  = live && (MY_IDX < idx_in) && (held_val_q > val_in) && (held_col_q != col_in);
	assign wr   = adv && live && (idx_in == MY_IDX);

	always_ff @(posedge clk) begin
		if (wr) begin
			held_val_q <= val_in;
			held_col_q <= col_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else if (adv) begin
			ctl_q <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			val_q <= val_in;
			col_q <= col_in;
			idx_q <= idx_in;
			cnt_q <= cnt_in + IDX_BITS'(hit);
		end
	end

	assign ctl_out = ctl_q;
	assign val_out = val_q;
	assign col_out = col_q;
	assign idx_out = idx_q;
	assign cnt_out = cnt_q;
endmodule

FILE: rtl/core/cic_acc.sv
// chain exit: saturating running total, overflow flag and result register
module cic_acc #(
	parameter int MAX_ITEMS = 1024
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         adv,
	input  cic_pkg::cic_ctl_t            ctl_in,
	input  logic [$clog2(MAX_ITEMS)-1:0] cnt_in,
	cic_out_if.source                    res
);
	import cic_pkg::*;

	logic [TOTAL_BITS-1:0] total_q;
	logic                  ovf_q;
	logic                  valid_q;
	logic [TOTAL_BITS-1:0] pair_total_q;
	logic                  overflowed_q;
	logic [TOTAL_BITS:0]   sum;
	logic [TOTAL_BITS-1:0] sat;

	assign sum = {1'b0, total_q} + (TOTAL_BITS+1)'(cnt_in);
	assign sat = (sum > {1'b0, TOTAL_MAX}) ? TOTAL_MAX : sum[TOTAL_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			ovf_q   <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			if (adv && ctl_in.valid) begin
				if (ctl_in.last) begin
					total_q <= '0;
					ovf_q   <= 1'b0;
				end else begin
					total_q <= sat;
					ovf_q   <= ovf_q | ctl_in.ovf;
				end
			end
			priority if (adv && ctl_in.valid && ctl_in.last) begin
				valid_q <= 1'b1;
			end else if (res.ready) begin
				valid_q <= 1'b0;
			end else begin
				// result still waiting for its reader
				valid_q <= valid_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && ctl_in.valid && ctl_in.last) begin
			pair_total_q <= sat;
			overflowed_q <= ovf_q | ctl_in.ovf;
		end
	end

	assign res.valid      = valid_q;
	assign res.pair_total = pair_total_q;
	assign res.overflowed = overflowed_q;
endmodule

FILE: rtl/core/colored_inversion_counter_top.sv
// colored inversion counter: systolic chain of item cells with a result accumulator
// result: the last item's request passes every cell register in turn, then the exit registers the result
// throughput: one item per cycle; the chain (and input) stalls only while a result waits
// reset: asynchronous, active low; clears the fill count, totals, flags and token valid bits
// held items need no clearing, each slot is rewritten before any later item reads it
module colored_inversion_counter_top #(
	parameter int MAX_ITEMS  = 1024,
	parameter int VALUE_BITS = 32,
	parameter int COLOR_BITS = 10
) (
	input  logic  clk,
	input  logic  arst_n,
	cic_in_if.sink     item,
	cic_out_if.source  result
);
	import cic_pkg::*;

	localparam int IDX_BITS = $clog2(MAX_ITEMS);
	localparam int CNT_BITS = $clog2(MAX_ITEMS + 1);
	localparam logic [CNT_BITS-1:0] FULL = CNT_BITS'(MAX_ITEMS);

	// token links between cells: link k feeds cell k, link MAX_ITEMS feeds the exit
	cic_ctl_t              ctl_c [0:MAX_ITEMS];
	logic [VALUE_BITS-1:0] val_c [0:MAX_ITEMS];
	logic [COLOR_BITS-1:0] col_c [0:MAX_ITEMS];
	logic [IDX_BITS-1:0]   idx_c [0:MAX_ITEMS];
	logic [IDX_BITS-1:0]   cnt_c [0:MAX_ITEMS];

	logic [CNT_BITS-1:0] held_q;   // items stored in the current sequence
	logic                adv;      // whole chain moves one cell
	logic                accept;

	// the chain only stops when a finished result sits unread in the output register
	assign adv        = !result.valid || result.ready;
	assign item.ready = adv;
	assign accept     = item.valid && adv;

	// fill count: slot for the next item, reset after the last one of a sequence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
		end else if (accept) begin
			priority if (item.is_last) begin
				held_q <= '0;
			end else if (held_q != FULL) begin
				held_q <= held_q + 1'b1;
			end else begin
				// store full: count stays at capacity
				held_q <= held_q;
			end
		end
	end

	// new request enters cell 0 carrying its slot index and an empty hit count;
	// a request beyond capacity is marked and passes the cells without effect
	assign ctl_c[0].valid = accept;
	assign ctl_c[0].last  = item.is_last;
	assign ctl_c[0].ovf   = (held_q == FULL);
	assign val_c[0]       = item.item_value;
	assign col_c[0]       = item.item_color;
	assign idx_c[0]       = held_q[IDX_BITS-1:0];
	assign cnt_c[0]       = '0;

	// each cell adds a hit for its held item if it came earlier, is greater and
	// differs in color; the cell whose index matches stores the request's item
	for (genvar k = 0; k < MAX_ITEMS; k++) begin : g_cell
		cic_cell #(
			.CELL_IDX   (k),
			.MAX_ITEMS  (MAX_ITEMS),
			.VALUE_BITS (VALUE_BITS),
			.COLOR_BITS (COLOR_BITS)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.adv     (adv),
			.ctl_in  (ctl_c[k]),
			.val_in  (val_c[k]),
			.col_in  (col_c[k]),
			.idx_in  (idx_c[k]),
			.cnt_in  (cnt_c[k]),
			.ctl_out (ctl_c[k+1]),
			.val_out (val_c[k+1]),
			.col_out (col_c[k+1]),
			.idx_out (idx_c[k+1]),
			.cnt_out (cnt_c[k+1])
		);
	end

	// exit: per-item counts folded into the sequence total, result on the last item
	cic_acc #(
		.MAX_ITEMS (MAX_ITEMS)
	) u_acc (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.ctl_in (ctl_c[MAX_ITEMS]),
		.cnt_in (cnt_c[MAX_ITEMS]),
		.res    (result)
	);

	// fill count never passes capacity
	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= FULL)
		else $error("fill count above capacity");

	// a last item restarts the fill count
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && item.is_last |=> held_q == '0)
		else $error("fill count not cleared after last item");

	// a last token leaving the chain always produces a result
	a_exit_result: assert property (@(posedge clk) disable iff (!arst_n)
		adv && ctl_c[MAX_ITEMS].valid && ctl_c[MAX_ITEMS].last |=> result.valid)
		else $error("sequence end without result");

	// an overflow token never carries hits to the exit
	a_ovf_no_hits: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_c[MAX_ITEMS].valid && ctl_c[MAX_ITEMS].ovf |-> cnt_c[MAX_ITEMS] == '0)
		else $error("overflow item was counted");
endmodule

FILE: verif/tb.sv
`timescale 1ns / 100ps
// self-checking testbench for colored_inversion_counter_top: sequences scored against a predictor
module tb;
	import cic_pkg::*;

	localparam int MAX_ITEMS   = 1024;
	localparam int VALUE_BITS  = 32;
	localparam int COLOR_BITS  = 10;
	// a result trails its last request by a full pass down the chain,
	// so allow that several times over plus the longest idle stretch
	localparam int QUIET_LIMIT = 4 * MAX_ITEMS + 1000;
	localparam int PHASE_ITEMS = 80;
	localparam int PHASE_COUNT = 8;

	typedef struct {
		logic [VALUE_BITS-1:0] value;
		logic [COLOR_BITS-1:0] color;
		logic                  last;
	} seq_item_t;

	typedef struct {
		logic [TOTAL_BITS-1:0] pair_total;
		logic                  overflowed;
	} seq_total_t;

	typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

	logic clk;
	logic arst_n;

	cic_in_if #(.VALUE_BITS(VALUE_BITS), .COLOR_BITS(COLOR_BITS)) item_ch ();
	cic_out_if result_ch ();

	colored_inversion_counter_top #(
		.MAX_ITEMS (MAX_ITEMS),
		.VALUE_BITS(VALUE_BITS),
		.COLOR_BITS(COLOR_BITS)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.item  (item_ch),
		.result(result_ch)
	);

	// items waiting to be offered, and sequence totals waiting to come out
	seq_item_t  pending_items[$];
	seq_total_t totals_due[$];
	seq_total_t total_want;

	// predictor copy of the item store
	logic [VALUE_BITS-1:0] held_val [MAX_ITEMS];
	logic [COLOR_BITS-1:0] held_col [MAX_ITEMS];
	int unsigned           held_n   = 0;
	logic [TOTAL_BITS-1:0] pair_sum = '0;
	logic                  ovf_seen = 1'b0;

	int unsigned send_idle_pct  = 0;
	int unsigned recv_stall_pct = 0;
	bit          item_taken     = 1'b0;

	int unsigned quiet_cycles    = 0;
	int unsigned items_in        = 0;
	int unsigned totals_out      = 0;
	int unsigned overflow_totals = 0;
	int unsigned fault_count     = 0;
	logic [TOTAL_BITS-1:0] peak_total = '0;

	// fold one accepted item into the predicted store; closes the sequence on its last item
	function automatic void tally_item(input seq_item_t it);
		int unsigned crossings;
		seq_total_t  done;
		crossings = 0;
		if (held_n < MAX_ITEMS) begin
			// only strictly larger values of another color count as inversions
			for (int k = 0; k < held_n; k++)
				if (held_val[k] > it.value && held_col[k] != it.color)
					crossings++;
			if (crossings > TOTAL_MAX - pair_sum)
				pair_sum = TOTAL_MAX;
			else
				pair_sum = TOTAL_BITS'(pair_sum + crossings);
			held_val[held_n] = it.value;
			held_col[held_n] = it.color;
			held_n++;
		end else begin
			// store full: item is dropped but flagged
			ovf_seen = 1'b1;
		end
		if (it.last) begin
			done.pair_total = pair_sum;
			done.overflowed = ovf_seen;
			totals_due = {totals_due, done};
			held_n   = 0;
			pair_sum = '0;
			ovf_seen = 1'b0;
		end
	endfunction

	function automatic void queue_item(input logic [VALUE_BITS-1:0] v,
		input logic [COLOR_BITS-1:0] c, input logic last);
		seq_item_t it;
		it.value = v;
		it.color = c;
		it.last  = last;
		pending_items = {pending_items, it};
	endfunction

	// one short sequence; the spreads of value and color are picked per sequence so that
	// ties, same-color pairs and full-range keys all show up often
	function automatic int queue_random_sequence();
		int len;
		int spread;
		int hues;
		logic [VALUE_BITS-1:0] v;
		logic [COLOR_BITS-1:0] c;
		len    = $urandom_range(24, 1);
		spread = $urandom_range(3);
		hues   = $urandom_range(2);
		for (int k = 0; k < len; k++) begin
			case (spread)
				0: v = $urandom_range(7);
				1: v = $urandom_range(255);
				2: v = $urandom();
				default: v = $urandom_range(1) ? {VALUE_BITS{1'b1}} - $urandom_range(3)
					: $urandom_range(3);
			endcase
			case (hues)
				0: c = COLOR_BITS'($urandom_range(2));
				1: c = COLOR_BITS'($urandom());
				default: c = $urandom_range(1) ? {COLOR_BITS{1'b1}} : {COLOR_BITS{1'b0}};
			endcase
			queue_item(v, c, k == len - 1);
		end
		return len;
	endfunction

	// clock, plus known levels on every block input from time zero
	initial begin
		clk                = 1'b0;
		arst_n             = 1'b0;
		item_ch.valid      = 1'b0;
		item_ch.item_value = '0;
		item_ch.item_color = '0;
		item_ch.is_last    = 1'b0;
		result_ch.ready    = 1'b0;
		forever #1 clk = ~clk;
	end

	// driver: inputs move on the falling edge only
	always @(negedge clk) begin
		if (!arst_n) begin
			item_ch.valid   <= 1'b0;
			result_ch.ready <= 1'b0;
		end else begin
			// a request on the bus stays put until it is taken
			if (!item_ch.valid || item_taken) begin
				item_taken = 1'b0;
				if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					item_ch.valid      <= 1'b1;
					item_ch.item_value <= pending_items[0].value;
					item_ch.item_color <= pending_items[0].color;
					item_ch.is_last    <= pending_items[0].last;
				end else begin
					item_ch.valid <= 1'b0;
				end
			end
			result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// monitor: both handshakes are sampled on the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (item_ch.valid && item_ch.ready) begin
				tally_item(pending_items.pop_front());
				item_taken = 1'b1;
				items_in++;
			end
			if (result_ch.valid && result_ch.ready) begin
				if (totals_due.size() == 0) begin
					$error("result with no sequence closed: pair_total %0d, overflowed %0d",
						result_ch.pair_total, result_ch.overflowed);
					fault_count++;
				end else begin
					total_want = totals_due.pop_front();
					if (result_ch.pair_total !== total_want.pair_total) begin
						$error("pair_total: expected %0d, got %0d",
							total_want.pair_total, result_ch.pair_total);
						fault_count++;
					end
					if (result_ch.overflowed !== total_want.overflowed) begin
						$error("overflowed: expected %0d, got %0d",
							total_want.overflowed, result_ch.overflowed);
						fault_count++;
					end
					totals_out++;
					if (total_want.overflowed)
						overflow_totals++;
					if (total_want.pair_total > peak_total)
						peak_total = total_want.pair_total;
				end
			end
			// watchdog counts edges with no request moving on either side
			if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
	end

	initial begin
		wait (quiet_cycles >= QUIET_LIMIT);
		$display("no request moved for %0d cycles, %0d results still due",
			QUIET_LIMIT, totals_due.size());
		$display("** colored_inversion_counter_top: FAILED **");
		$finish;
	end

	initial begin : stimulus
		logic [VALUE_BITS-1:0] v;
		logic [COLOR_BITS-1:0] c;
		logic [COLOR_BITS-1:0] hue_mask;
		idle_mode_t            mode;
		int                    phase_items;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// lone item: nothing to pair with
		queue_item('0, '0, 1'b1);
		// extreme keys and colors; the first all-ones key shares its color with the later
		// zero-color items, so those same-color pairs drop out
		queue_item({VALUE_BITS{1'b1}}, '0, 1'b0);
		queue_item('0, {COLOR_BITS{1'b1}}, 1'b0);
		queue_item('0, '0, 1'b0);
		queue_item({VALUE_BITS{1'b1}}, {COLOR_BITS{1'b1}}, 1'b0);
		queue_item(7, '0, 1'b1);
		// equal keys never count
		queue_item(5, COLOR_BITS'(1), 1'b0);
		queue_item(5, COLOR_BITS'(2), 1'b0);
		queue_item(5, COLOR_BITS'(3), 1'b1);
		// descending keys of one color never count
		queue_item(9, COLOR_BITS'(4), 1'b0);
		queue_item(8, COLOR_BITS'(4), 1'b0);
		queue_item(7, COLOR_BITS'(4), 1'b1);
		// alternating bit patterns
		queue_item(32'hAAAA_AAAA, 10'h2AA, 1'b0);
		queue_item(32'h5555_5555, 10'h155, 1'b1);

		// one full store: strictly falling keys with all-distinct colors give the largest
		// total, then three items past capacity, the last of them closing the sequence
		hue_mask = COLOR_BITS'($urandom());
		for (int k = 0; k < MAX_ITEMS + 3; k++) begin
			v = $urandom();
			c = COLOR_BITS'($urandom());
			if (k < MAX_ITEMS) begin
				v[VALUE_BITS-1 -: COLOR_BITS] = COLOR_BITS'(MAX_ITEMS - 1 - k);
				c = COLOR_BITS'(k) ^ hue_mask;
			end
			queue_item(v, c, k == MAX_ITEMS + 2);
		end
		wait (pending_items.size() == 0);

		// random short sequences under each idling pattern in turn
		for (int p = 0; p < PHASE_COUNT; p++) begin
			mode = idle_mode_t'((p + 1) % 4);
			case (mode)
				IDLE_SENDER: begin
					send_idle_pct  = 61;
					recv_stall_pct = 0;
				end
				IDLE_RECEIVER: begin
					send_idle_pct  = 0;
					recv_stall_pct = 61;
				end
				IDLE_BOTH: begin
					send_idle_pct  = 10;
					recv_stall_pct = 10;
				end
				default: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
				end
			endcase
			phase_items = 0;
			while (phase_items < PHASE_ITEMS)
				phase_items += queue_random_sequence();
			wait (pending_items.size() == 0);
		end

		// drain, then watch a full chain pass for anything unexpected
		wait (totals_due.size() == 0);
		repeat (MAX_ITEMS + 16) @(posedge clk);

		$display("covered %0d items in %0d sequences, %0d of them past store capacity",
			items_in, totals_out, overflow_totals);
		$display("largest pair total seen %0d, mismatches %0d", peak_total, fault_count);
		if (fault_count == 0)
			$display("** colored_inversion_counter_top: PASSED **");
		else
			$display("** colored_inversion_counter_top: FAILED **");
		$finish;
	end

endmodule
